FILE: hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and codes for the ring-buffer deque: operation and status
// codes, controller states and the request/response word layouts.
// ----------------------------------------------------------------------------
package cbd_pkg;

   // Fixed widths of the word fields.
   localparam int OP_W    = 2;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   typedef struct packed {
      op_type              operation;
      logic [DATA_W-1:0]   entry_value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   popped_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

endpackage

FILE: hdl/circular_buffer_deque_core.sv
// Timing: a push or a refused operation shows its response word in the cycle
//   after acceptance; a successful pop passes through the memory read register
//   and then the response register. One push or refused word is taken per cycle
//   while the output is free; no new word is taken while a pop waits on memory.
// Reset: pointers and count return to an empty ring; the ring memory is
//   left as is, since no slot is read before a push has filled it.
// ----------------------------------------------------------------------------
// circular_buffer_deque_core
// Double-ended queue kept in a ring memory with wrapping front and back
// pointers and an entry count. Pushes to a full ring and pops from an empty
// ring are refused with a status code; every request gives one response.
// ----------------------------------------------------------------------------
module circular_buffer_deque_core #(
   parameter int DEPTH       = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbd_pkg::rsp_type  rsp_data
);

   localparam int PtrW    = $clog2(DEPTH);
   localparam int CntW    = $clog2(DEPTH + 1);
   localparam int SumW    = CntW + 2;
   localparam int DataW   = cbd_pkg::DATA_W;
   localparam int OutCntW = cbd_pkg::COUNT_W;

   localparam logic [PtrW-1:0] LastSlot  = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   cbd_pkg::state_type  state_ff, state_in;
   logic [PtrW-1:0]     front_ff, front_in;   // free slot for next front push
   logic [PtrW-1:0]     back_ff, back_in;     // free slot for next back push
   logic [CntW-1:0]     count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cbd_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // Ring memory with registered read data.
   logic [ENTRY_WIDTH-1:0] ring_mem [DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;

   // ------------------------------------------------------------------------
   // Decode of the incoming word
   // ------------------------------------------------------------------------
   logic             out_free;
   logic             accept;
   logic             is_push, is_front;
   logic             is_full, is_empty;
   logic [PtrW-1:0]  front_up, back_down;
   logic             wr_en, rd_en;
   logic [PtrW-1:0]  wr_addr, rd_addr;
   logic             load_read;

   // Output register may take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   always_comb begin
      is_push  = (req_data.operation == cbd_pkg::OP_PUSH_FRONT) ||
                 (req_data.operation == cbd_pkg::OP_PUSH_BACK);
      is_front = (req_data.operation == cbd_pkg::OP_PUSH_FRONT) ||
                 (req_data.operation == cbd_pkg::OP_POP_FRONT);
      is_full  = (count_ff == FullCount);
      is_empty = (count_ff == '0);
      // Wrap the pointers by hand: depth need not be a power of two.
      front_up  = (front_ff == LastSlot) ? '0 : front_ff + PtrW'(1);
      back_down = (back_ff == '0) ? LastSlot : back_ff - PtrW'(1);
   end

   // Memory access: a push writes the free slot, a pop reads the slot just
   // beyond the pointer it moves.
   always_comb begin
      wr_en   = accept && is_push && !is_full;
      rd_en   = accept && !is_push && !is_empty;
      wr_addr = is_front ? front_ff : back_ff;
      rd_addr = is_front ? front_up : back_down;
   end

   // ------------------------------------------------------------------------
   // Pointer and count update, at acceptance
   // ------------------------------------------------------------------------
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      if (wr_en) begin
         count_in = count_ff + CntW'(1);
         if (is_front) begin
            front_in = (front_ff == '0) ? LastSlot : front_ff - PtrW'(1);
         end else begin
            back_in = (back_ff == LastSlot) ? '0 : back_ff + PtrW'(1);
         end
      end else if (rd_en) begin
         count_in = count_ff - CntW'(1);
         if (is_front) begin
            front_in = front_up;
         end else begin
            back_in = back_down;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Controller: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbd_pkg::S_IDLE: begin
            if (rd_en) begin
               state_in = cbd_pkg::S_READ;
            end
         end
         cbd_pkg::S_READ: begin
            if (out_free) begin
               state_in = cbd_pkg::S_IDLE;
            end
         end
         default: state_in = cbd_pkg::S_IDLE;
      endcase
   end

   // Controller: outputs. Hold off new words while a pop waits on memory.
   always_comb begin
      req_ready = 1'b0;
      load_read = 1'b0;
      unique case (state_ff)
         cbd_pkg::S_IDLE: req_ready = out_free;
         cbd_pkg::S_READ: load_read = out_free;
         default: begin
            req_ready = 1'b0;
            load_read = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load_read) begin
         // Pop completes: count was already updated at acceptance.
         rsp_valid_in             = 1'b1;
         rsp_data_in.status       = cbd_pkg::ST_DONE;
         rsp_data_in.popped_value = DataW'(rd_data_ff);
         rsp_data_in.entry_count  = OutCntW'(count_ff);
      end else if (accept && !rd_en) begin
         // Push or refused operation: answer right away.
         rsp_valid_in             = 1'b1;
         rsp_data_in.popped_value = '0;
         rsp_data_in.entry_count  = OutCntW'(count_in);
         if (is_push) begin
            rsp_data_in.status = is_full ? cbd_pkg::ST_FULL : cbd_pkg::ST_DONE;
         end else begin
            rsp_data_in.status = cbd_pkg::ST_EMPTY;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbd_pkg::S_IDLE;
         front_ff     <= '0;
         back_ff      <= PtrW'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Ring memory: one write port, one registered read port. A read is only
   // issued on a cycle without a write, so the two never collide.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= ENTRY_WIDTH'(req_data.entry_value);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   logic [SumW-1:0] ring_span;
   assign ring_span = SumW'(front_ff) + SumW'(count_ff) + SumW'(1);

   // Count never exceeds the ring depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("entry count above depth");

   // Back pointer sits count+1 slots above the front pointer, modulo depth.
   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      (SumW'(back_ff) == ring_span) || (SumW'(back_ff) + SumW'(DEPTH) == ring_span) ||
      (SumW'(back_ff) + SumW'(2 * DEPTH) == ring_span))
      else $error("front/back pointers disagree with count");

   // A full refusal leaves the ring full.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == cbd_pkg::ST_FULL) |-> count_ff == FullCount)
      else $error("full status reported with free slots");

   // A successful pop hands its result over as soon as the output is free.
   a_pop_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbd_pkg::S_READ) && out_free |=> rsp_valid_ff &&
         (rsp_data_ff.status == cbd_pkg::ST_DONE))
      else $error("pop result not delivered");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_buffer_deque_core. A short table of
// directed words covers the empty and full refusals, the extreme values and
// the fill to capacity. A long stream of random push and pop bursts follows.
// Every response word is checked field by field against a local model of
// the deque or against a response typed into the table by hand.
// ----------------------------------------------------------------------------
module tb;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_WORDS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   // Receiver hold-off window and calm stretches (no idling) on each side.
   localparam int HOLD_START   = 300;
   localparam int HOLD_CYCLES  = 80;
   localparam int TX_CALM_LO   = 600;
   localparam int TX_CALM_HI   = 800;
   localparam int RX_CALM_LO   = 1800;
   localparam int RX_CALM_HI   = 2300;
   localparam int DRAIN_CYCLES = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cbd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cbd_pkg::rsp_type rsp_data;

   circular_buffer_deque_core #(
      .DEPTH       (RING_DEPTH),
      .ENTRY_WIDTH (cbd_pkg::DATA_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Deque model: ring contents, both free-slot pointers and the fill level.
   // front_slot points at the slot the next front push fills and walks down;
   // back_slot points at the slot the next back push fills and walks up.
   // -------------------------------------------------------------------------
   logic [cbd_pkg::DATA_W-1:0]  ring_words [RING_DEPTH];
   int                          front_slot = 0;
   int                          back_slot  = 1;
   logic [cbd_pkg::COUNT_W-1:0] held_words = '0;

   int push_count   = 0;
   int pop_count    = 0;
   int full_count   = 0;
   int empty_count  = 0;
   int error_count  = 0;

   // Responses still owed by the block, oldest first.
   cbd_pkg::rsp_type owed_rsp [$];

   // Apply one word to the model and return the response it must produce.
   function automatic cbd_pkg::rsp_type deque_apply(cbd_pkg::req_type w);
      cbd_pkg::rsp_type r;
      r.status       = cbd_pkg::ST_DONE;
      r.popped_value = '0;
      case (w.operation) inside
         cbd_pkg::OP_PUSH_FRONT, cbd_pkg::OP_PUSH_BACK: begin
            if (held_words == RING_DEPTH) begin
               // full ring: refuse, leave everything as is
               r.status = cbd_pkg::ST_FULL;
               full_count++;
            end else if (w.operation == cbd_pkg::OP_PUSH_FRONT) begin
               ring_words[front_slot] = w.entry_value;
               front_slot = (front_slot == 0) ? RING_DEPTH - 1 : front_slot - 1;
               held_words++;
               push_count++;
            end else begin
               ring_words[back_slot] = w.entry_value;
               back_slot = (back_slot == RING_DEPTH - 1) ? 0 : back_slot + 1;
               held_words++;
               push_count++;
            end
         end
         default: begin
            if (held_words == 0) begin
               // empty ring: refuse, popped value stays zero
               r.status = cbd_pkg::ST_EMPTY;
               empty_count++;
            end else if (w.operation == cbd_pkg::OP_POP_FRONT) begin
               front_slot = (front_slot == RING_DEPTH - 1) ? 0 : front_slot + 1;
               r.popped_value = ring_words[front_slot];
               held_words--;
               pop_count++;
            end else begin
               back_slot = (back_slot == 0) ? RING_DEPTH - 1 : back_slot - 1;
               r.popped_value = ring_words[back_slot];
               held_words--;
               pop_count++;
            end
         end
      endcase
      r.entry_count = held_words;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Directed table. Rows with pinned_rsp set carry a response typed in by
   // hand; the others take the model's answer.
   // -------------------------------------------------------------------------
   typedef struct {
      cbd_pkg::req_type word;
      bit               pinned_rsp;
      cbd_pkg::rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows [$];

   function automatic void add_row(cbd_pkg::op_type op,
                                   logic [cbd_pkg::DATA_W-1:0] value, bit pinned,
                                   cbd_pkg::status_type st,
                                   logic [cbd_pkg::DATA_W-1:0] popped,
                                   logic [cbd_pkg::COUNT_W-1:0] level);
      stim_row_type row;
      row.word.operation      = op;
      row.word.entry_value    = value;
      row.pinned_rsp          = pinned;
      row.want.status         = st;
      row.want.popped_value   = popped;
      row.want.entry_count    = level;
      directed_rows.push_back(row);
   endfunction

   // Offer one word, wait for the handshake, then log what it must produce.
   // Keep valid high straight into the next word unless a gap is drawn.
   task automatic offer_word(input cbd_pkg::req_type w, input bit pinned,
                             input cbd_pkg::rsp_type want, input bit calm);
      int               gap;
      cbd_pkg::rsp_type predicted;
      gap = 0;
      if (!calm && $urandom_range(99) < 24)
         gap = $urandom_range(2, 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predicted = deque_apply(w);
      owed_rsp.push_back(pinned ? want : predicted);
   endtask

   // -------------------------------------------------------------------------
   // Sender: reset, directed table, random bursts, drain, verdict.
   // -------------------------------------------------------------------------
   initial begin
      cbd_pkg::req_type w;
      cbd_pkg::rsp_type none;
      int               burst_left;
      int               push_pct;
      none = '0;
      burst_left = 0;
      push_pct   = 50;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Refusals on a fresh ring, then extreme values through both ends.
      add_row(cbd_pkg::OP_POP_FRONT,  32'h1234_5678, 1'b1, cbd_pkg::ST_EMPTY, '0, 5'd0);
      add_row(cbd_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, cbd_pkg::ST_EMPTY, '0, 5'd0);
      add_row(cbd_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, cbd_pkg::ST_DONE,  '0, 5'd1);
      add_row(cbd_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b1, cbd_pkg::ST_DONE,  '0, 5'd2);
      add_row(cbd_pkg::OP_POP_FRONT,  32'h0000_0000, 1'b1, cbd_pkg::ST_DONE,
              32'hFFFF_FFFF, 5'd1);
      add_row(cbd_pkg::OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, cbd_pkg::ST_DONE,
              32'h0000_0000, 5'd0);
      add_row(cbd_pkg::OP_POP_BACK,   32'h0000_0000, 1'b1, cbd_pkg::ST_EMPTY, '0, 5'd0);
      // Fill to capacity from both ends, then try to push past it.
      for (int k = 0; k < RING_DEPTH; k++)
         add_row(k[0] ? cbd_pkg::OP_PUSH_BACK : cbd_pkg::OP_PUSH_FRONT,
                 (32'h1111_1111 * k) ^ 32'hA5A5_5A5A, 1'b0, cbd_pkg::ST_DONE, '0, '0);
      add_row(cbd_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, cbd_pkg::ST_FULL, '0, 5'd16);
      add_row(cbd_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b1, cbd_pkg::ST_FULL, '0, 5'd16);

      foreach (directed_rows[i])
         offer_word(directed_rows[i].word, directed_rows[i].pinned_rsp,
                    directed_rows[i].want, 1'b0);

      // Random bursts, each leaning toward pushes, pops or neither, so the
      // ring swings between full and empty and the pointers wrap often.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            case ($urandom_range(2))
               0:       push_pct = 85;
               1:       push_pct = 15;
               default: push_pct = 50;
            endcase
         end
         burst_left--;
         if ($urandom_range(99) < push_pct)
            w.operation = $urandom_range(1) ? cbd_pkg::OP_PUSH_BACK
                                            : cbd_pkg::OP_PUSH_FRONT;
         else
            w.operation = $urandom_range(1) ? cbd_pkg::OP_POP_BACK
                                            : cbd_pkg::OP_POP_FRONT;
         case ($urandom_range(7))
            0:       w.entry_value = '0;
            1:       w.entry_value = '1;
            default: w.entry_value = $urandom;
         endcase
         offer_word(w, 1'b0, none, (n >= TX_CALM_LO && n < TX_CALM_HI));
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed response, then let the pipe settle.
      while (owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pushes and %0d pops; %0d refused as full, %0d as empty.",
               push_count, pop_count, full_count, empty_count);
      $display("Mismatches seen: %0d", error_count);
      if (error_count == 0)
         $display("circular_buffer_deque_core verification clean");
      else
         $display("circular_buffer_deque_core verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off so the block backs up into
   // its input, and a calm stretch with ready held high.
   // -------------------------------------------------------------------------
   initial begin
      int rx_cycle;
      rx_cycle = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
            rsp_ready <= 1'b0;
         else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 24);
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: match each accepted word against the oldest owed one.
   // -------------------------------------------------------------------------
   initial begin
      cbd_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (owed_rsp.size() == 0) begin
               $error("unexpected response word: status %0d popped_value 0x%08h count %0d",
                      rsp_data.status, rsp_data.popped_value, rsp_data.entry_count);
               error_count++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.popped_value !== want.popped_value) begin
                  $error("popped_value: expected 0x%08h, got 0x%08h",
                         want.popped_value, rsp_data.popped_value);
                  error_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_count++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: stop a hung run.
   // -------------------------------------------------------------------------
   initial begin
      int run_cycles;
      run_cycles = 0;
      while (run_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         run_cycles++;
      end
      $display("Run stopped after %0d cycles with %0d responses owed",
               run_cycles, owed_rsp.size());
      $display("circular_buffer_deque_core verification failed");
      $finish;
   end

endmodule
